@@ sv/strand_pair_hbond_energy_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the strand pair energy RTL
// Both macros sample on i_clk and are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STRAND_PAIR_HBOND_ENERGY_TOP_MACROS_SVH
`define STRAND_PAIR_HBOND_ENERGY_TOP_MACROS_SVH

// same-cycle implication
`define SPHE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPHE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sphe_pkg.sv @@
// ----------------------------------------------------------------------------
// sphe_pkg
// Types and constants of the strand pair energy scorer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sphe_pkg;

    localparam int TABLE_DEPTH = 210;
    localparam int ADDR_W      = 8;
    localparam int ODDS_W      = 16;
    localparam int SUM_W       = 24;
    localparam int RES_W       = 5;

    localparam logic [RES_W-1:0] RES_LIMIT = 5'd19;
    localparam logic [RES_W-1:0] GLY_CODE  = 5'd7;
    localparam logic [8:0]       RES_COUNT = 9'd20;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_RESIDUE = 1'b1;

    typedef enum logic [1:0] {
        TBL_WEAK   = 2'd0,
        TBL_STRONG = 2'd1,
        TBL_VDW    = 2'd2
    } t_tbl_sel;

    // terms to apply for one residue word, travels with the table reads
    typedef struct packed {
        logic valid;
        logic use_weak;
        logic use_strong;
        logic use_vdw;
        logic last;
    } t_term_ctrl;

endpackage

@@ sv/sphe_odds_ram.sv @@
// ----------------------------------------------------------------------------
// sphe_odds_ram
// One log-odds table: single write port, single registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sphe_odds_ram (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [sphe_pkg::ADDR_W-1:0]         i_waddr,
    input  logic signed [sphe_pkg::ODDS_W-1:0]  i_wdata,
    input  logic                                i_re,
    input  logic [sphe_pkg::ADDR_W-1:0]         i_raddr,
    output logic signed [sphe_pkg::ODDS_W-1:0]  o_rdata
);
    import sphe_pkg::*;

    logic signed [ODDS_W-1:0] mem [TABLE_DEPTH];
    logic signed [ODDS_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/sphe_index.sv @@
// ----------------------------------------------------------------------------
// sphe_index
// Front stage: table writes, pair index generation and strand position state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "strand_pair_hbond_energy_top_macros.svh"

module sphe_index (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_advance,
    input  logic                            i_req_type,
    input  logic [1:0]                      i_table_select,
    input  logic [sphe_pkg::ADDR_W-1:0]     i_entry_index,
    input  logic                            i_hbond_pattern,
    input  logic                            i_orientation,
    input  logic [sphe_pkg::RES_W-1:0]      i_residue_a,
    input  logic [sphe_pkg::RES_W-1:0]      i_residue_b,
    input  logic                            i_last_element,
    output logic [2:0]                      o_wr_en,
    output logic [sphe_pkg::ADDR_W-1:0]     o_weak_raddr,
    output logic [sphe_pkg::ADDR_W-1:0]     o_pair_raddr,
    output sphe_pkg::t_term_ctrl            o_ctrl
);
    import sphe_pkg::*;

    // unordered pair index; lo <= hi assumed
    function automatic logic [ADDR_W-1:0] pair_index(input logic [RES_W-1:0] lo,
                                                     input logic [RES_W-1:0] hi);
        logic [8:0] base;
        base = 9'(lo) * RES_COUNT - ((9'(lo) * (9'(lo) + 9'd1)) >> 1);
        return ADDR_W'(base + 9'(hi));
    endfunction

    logic [RES_W-1:0] r_prev_first;
    logic             r_have_prev;
    logic             r_pos_odd;
    t_term_ctrl       r_ctrl;

    logic [RES_W-1:0] first, second;
    logic [RES_W-1:0] w_lo, w_hi, p_lo, p_hi;
    logic             weak_ok, pair_ok, strong_slot, gly_pair, load_ok, is_res;
    t_term_ctrl       n_ctrl;

    always_comb begin
        first  = i_orientation ? i_residue_a : i_residue_b;
        second = i_orientation ? i_residue_b : i_residue_a;

        w_lo = (r_prev_first <= second) ? r_prev_first : second;
        w_hi = (r_prev_first <= second) ? second : r_prev_first;
        p_lo = (first <= second) ? first : second;
        p_hi = (first <= second) ? second : first;

        weak_ok = r_have_prev && (r_prev_first <= RES_LIMIT) && (second <= RES_LIMIT);
        pair_ok = (first <= RES_LIMIT) && (second <= RES_LIMIT);

        // out-of-range pairs read address zero; the data is not used
        o_weak_raddr = weak_ok ? pair_index(w_lo, w_hi) : '0;
        o_pair_raddr = pair_ok ? pair_index(p_lo, p_hi) : '0;

        strong_slot = (r_pos_odd == i_hbond_pattern);
        gly_pair    = (first == GLY_CODE) && (second == GLY_CODE);
        is_res      = i_accept && (i_req_type == REQ_RESIDUE);

        n_ctrl.valid      = is_res;
        n_ctrl.use_weak   = weak_ok;
        n_ctrl.use_strong = pair_ok && strong_slot;
        n_ctrl.use_vdw    = pair_ok && !strong_slot && !gly_pair;
        n_ctrl.last       = i_last_element;

        load_ok    = i_accept && (i_req_type == REQ_LOAD) && (32'(i_entry_index) < TABLE_DEPTH);
        o_wr_en[0] = load_ok && (i_table_select == TBL_WEAK);
        o_wr_en[1] = load_ok && (i_table_select == TBL_STRONG);
        o_wr_en[2] = load_ok && (i_table_select == TBL_VDW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_first <= '0;
            r_have_prev  <= 1'b0;
            r_pos_odd    <= 1'b0;
        end else if (is_res) begin
            if (i_last_element) begin
                r_prev_first <= '0;
                r_have_prev  <= 1'b0;
                r_pos_odd    <= 1'b0;
            end else begin
                r_prev_first <= first;
                r_have_prev  <= 1'b1;
                r_pos_odd    <= !r_pos_odd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_advance) begin
            r_ctrl <= n_ctrl;
        end
    end

    assign o_ctrl = r_ctrl;

    `SPHE_ASSERT_NOW(a_fresh_strand_clean, !r_have_prev, (r_prev_first == '0) && !r_pos_odd, "sphe_index: stale position state at strand start")
    `SPHE_ASSERT_NXT(a_last_clears, is_res && i_last_element, !r_have_prev && !r_pos_odd, "sphe_index: position state not cleared after last word")
    `SPHE_ASSERT_NOW(a_one_table_write, 1'b1, $onehot0(o_wr_en), "sphe_index: more than one table written")

endmodule

@@ sv/sphe_accum.sv @@
// ----------------------------------------------------------------------------
// sphe_accum
// Saturating accumulation of the weak and strong/vdw terms, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "strand_pair_hbond_energy_top_macros.svh"

module sphe_accum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_out_stall,
    input  sphe_pkg::t_term_ctrl                i_ctrl,
    input  logic signed [sphe_pkg::ODDS_W-1:0]  i_weak,
    input  logic signed [sphe_pkg::ODDS_W-1:0]  i_strong,
    input  logic signed [sphe_pkg::ODDS_W-1:0]  i_vdw,
    output logic                                o_advance,
    output logic                                o_out_valid,
    output logic signed [sphe_pkg::SUM_W-1:0]   o_pair_energy,
    output logic                                o_saturated
);
    import sphe_pkg::*;

    logic signed [SUM_W-1:0] r_sum;
    logic                    r_clip;
    logic                    r_out_valid;
    logic signed [SUM_W-1:0] r_out_energy;
    logic                    r_out_sat;

    logic signed [SUM_W:0]   wide1, wide2;
    logic signed [SUM_W-1:0] sum1, sum2;
    logic                    clip1, clip2;
    logic signed [ODDS_W-1:0] term2;
    logic                    step;

    always_comb begin
        o_advance = !(r_out_valid && i_out_stall);
        step      = o_advance && i_ctrl.valid;

        // weak term first; overflow when the top two bits differ
        wide1 = {r_sum[SUM_W-1], r_sum} + (SUM_W+1)'(i_weak);
        if (!i_ctrl.use_weak) begin
            sum1  = r_sum;
            clip1 = r_clip;
        end else if (wide1[SUM_W] != wide1[SUM_W-1]) begin
            sum1  = wide1[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
            clip1 = 1'b1;
        end else begin
            sum1  = wide1[SUM_W-1:0];
            clip1 = r_clip;
        end

        term2 = i_ctrl.use_strong ? i_strong : i_vdw;
        wide2 = {sum1[SUM_W-1], sum1} + (SUM_W+1)'(term2);
        if (!(i_ctrl.use_strong || i_ctrl.use_vdw)) begin
            sum2  = sum1;
            clip2 = clip1;
        end else if (wide2[SUM_W] != wide2[SUM_W-1]) begin
            sum2  = wide2[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
            clip2 = 1'b1;
        end else begin
            sum2  = wide2[SUM_W-1:0];
            clip2 = clip1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_clip <= 1'b0;
        end else if (step) begin
            if (i_ctrl.last) begin
                r_sum  <= '0;
                r_clip <= 1'b0;
            end else begin
                r_sum  <= sum2;
                r_clip <= clip2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= i_ctrl.valid && i_ctrl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && i_ctrl.last) begin
            r_out_energy <= sum2;
            r_out_sat    <= clip2;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pair_energy = r_out_energy;
    assign o_saturated   = r_out_sat;

    `SPHE_ASSERT_NOW(a_result_from_last, $rose(r_out_valid), $past(step && i_ctrl.last), "sphe_accum: result word without a last residue")
    `SPHE_ASSERT_NXT(a_sum_cleared, step && i_ctrl.last, (r_sum == '0) && !r_clip, "sphe_accum: sum not cleared after last residue")
    `SPHE_ASSERT_NXT(a_idle_holds_sum, !step, $stable(r_sum) && $stable(r_clip), "sphe_accum: sum moved without a residue word")

endmodule

@@ sv/strand_pair_hbond_energy_top.sv @@
// Result path: a last residue word passes the table read and control registers,
// then the accumulator result register that drives o_out_valid and o_pair_energy.
// Throughput: one word (load or residue) per cycle while o_in_stall is low;
// table reads and the two saturating adds sit in one registered stage each.
// Reset: clears sum, clip flag, strand position state and pipeline valids;
// the three tables are not cleared and hold no defined value until loaded.
// ----------------------------------------------------------------------------
// strand_pair_hbond_energy_top
// Beta strand pairing energy scorer: table loads and streamed residue pairs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module strand_pair_hbond_energy_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic [1:0]                          i_table_select,
    input  logic [sphe_pkg::ADDR_W-1:0]         i_entry_index,
    input  logic signed [sphe_pkg::ODDS_W-1:0]  i_entry_value,
    input  logic                                i_hbond_pattern,
    input  logic                                i_orientation,
    input  logic [sphe_pkg::RES_W-1:0]          i_residue_a,
    input  logic [sphe_pkg::RES_W-1:0]          i_residue_b,
    input  logic                                i_last_element,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [sphe_pkg::SUM_W-1:0]   o_pair_energy,
    output logic                                o_saturated
);
    import sphe_pkg::*;

    logic                     advance, accept;
    logic [2:0]               wr_en;
    logic [ADDR_W-1:0]        weak_raddr, pair_raddr;
    t_term_ctrl               ctrl;
    logic signed [ODDS_W-1:0] weak_q, strong_q, vdw_q;

    assign o_in_stall = !advance;
    assign accept     = i_in_valid && advance;

    sphe_index u_index (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_advance      (advance),
        .i_req_type     (i_req_type),
        .i_table_select (i_table_select),
        .i_entry_index  (i_entry_index),
        .i_hbond_pattern(i_hbond_pattern),
        .i_orientation  (i_orientation),
        .i_residue_a    (i_residue_a),
        .i_residue_b    (i_residue_b),
        .i_last_element (i_last_element),
        .o_wr_en        (wr_en),
        .o_weak_raddr   (weak_raddr),
        .o_pair_raddr   (pair_raddr),
        .o_ctrl         (ctrl)
    );

    sphe_odds_ram u_weak_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en[0]),
        .i_waddr(i_entry_index),
        .i_wdata(i_entry_value),
        .i_re   (advance),
        .i_raddr(weak_raddr),
        .o_rdata(weak_q)
    );

    sphe_odds_ram u_strong_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en[1]),
        .i_waddr(i_entry_index),
        .i_wdata(i_entry_value),
        .i_re   (advance),
        .i_raddr(pair_raddr),
        .o_rdata(strong_q)
    );

    sphe_odds_ram u_vdw_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en[2]),
        .i_waddr(i_entry_index),
        .i_wdata(i_entry_value),
        .i_re   (advance),
        .i_raddr(pair_raddr),
        .o_rdata(vdw_q)
    );

    sphe_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_out_stall  (i_out_stall),
        .i_ctrl       (ctrl),
        .i_weak       (weak_q),
        .i_strong     (strong_q),
        .i_vdw        (vdw_q),
        .o_advance    (advance),
        .o_out_valid  (o_out_valid),
        .o_pair_energy(o_pair_energy),
        .o_saturated  (o_saturated)
    );

endmodule
